>>> rtl/core/dbhs_pkg.sv
// Package for the handshake greeting validator: beat types, parse phases,
// verdict codes and the printable-character check. No dependencies.
`default_nettype none

package dbhs_pkg;

    localparam int unsigned POS_W   = 25;
    localparam int unsigned VLEN_W  = 24;
    localparam int unsigned VERD_W  = 2;
    localparam int unsigned SKIP_W  = 3;

    // fixed header values and printable character bounds
    localparam logic [7:0] PROTO_VERSION = 8'h0A;
    localparam logic [7:0] SEQ_ZERO      = 8'h00;
    localparam logic [7:0] STR_END       = 8'h00;
    localparam logic [7:0] PRINT_LO      = 8'h20;
    localparam logic [7:0] PRINT_HI      = 8'h7E;

    // header byte offsets
    localparam logic [POS_W-1:0] POS_LEN0 = POS_W'(0);
    localparam logic [POS_W-1:0] POS_LEN1 = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LEN2 = POS_W'(2);
    localparam logic [POS_W-1:0] POS_SEQ  = POS_W'(3);
    localparam logic [POS_W-1:0] POS_PROT = POS_W'(4);
    localparam logic [POS_W-1:0] POS_BODY = POS_W'(5);
    localparam logic [POS_W-1:0] POS_MAX  = {POS_W{1'b1}};

    // header bytes outside the length value: the length field and sequence byte
    localparam logic [POS_W-1:0] SPAN_EXTRA = POS_W'(4);

    localparam logic [SKIP_W-1:0] SKIP_FIRST  = SKIP_W'(4);
    localparam logic [SKIP_W-1:0] SKIP_SECOND = SKIP_W'(5);

    typedef enum logic [VERD_W-1:0] {
        VERD_IN_PROCESS = 2'd0,
        VERD_MATCH      = 2'd1,
        VERD_NO_MATCH   = 2'd2
    } t_verdict;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_VERSION = 3'd1,
        PH_SKIP4   = 3'd2,
        PH_SECOND  = 3'd3,
        PH_SKIP5   = 3'd4,
        PH_NEED    = 3'd5,
        PH_DONE    = 3'd6
    } t_phase;

    // one input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       from_responder;
        logic       empty_packet;
    } t_beat;

    // one result from the parser
    typedef struct packed {
        logic              valid;
        t_verdict          verdict;
        logic [VLEN_W-1:0] version_length;
    } t_result;

    function automatic logic is_printable(input logic [7:0] b);
        return (b >= PRINT_LO) && (b <= PRINT_HI);
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/db_handshake_greeting_validator.sv
// Top level of the handshake greeting validator: input register, parser
// and result register with stream handshakes. Depends on dbhs_pkg, dbhs_parser.
`default_nettype none

// Checks a packet, one byte per beat, for a database server greeting and
// gives one result beat on the packet's last byte (tlast) or on an empty
// packet marker. The block takes one beat every clock cycle as long as the
// result side keeps up; a taken beat is held in the input register and its
// result then in the result register. Only the result register and the
// input register hold beats, so a stall on the result side stops intake
// once both are full. Non-last beats give no result beat.
module db_handshake_greeting_validator
    import dbhs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,   // last_byte
    input  wire logic [1:0]  s_axis_tuser,   // [0] from_responder, [1] empty_packet
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // [1:0] verdict, [25:2] version_length
);

    logic    r_in_vld;
    t_beat   r_in;
    logic    r_out_vld;
    t_result r_out;

    logic    out_free;
    logic    step;
    t_result result;

    assign out_free      = !r_out_vld || m_axis_tready;
    assign step          = r_in_vld && out_free;
    assign s_axis_tready = !r_in_vld || out_free;

    dbhs_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_beat   (r_in),
        .o_result (result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.data_byte      <= s_axis_tdata;
            r_in.last_byte      <= s_axis_tlast;
            r_in.from_responder <= s_axis_tuser[0];
            r_in.empty_packet   <= s_axis_tuser[1];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= result.valid;
        end
        if (out_free && result.valid) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {6'd0, r_out.version_length, r_out.verdict};

endmodule

`default_nettype wire

>>> rtl/core/dbhs_parser.sv
// Greeting parser: holds the per-packet parse state and works out the
// result for the beat in the input register. Depends on dbhs_pkg.
`default_nettype none

module dbhs_parser
    import dbhs_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_step,
    input  wire t_beat   i_beat,
    output t_result      o_result
);

    logic [POS_W-1:0]  r_pos,     n_pos;
    logic [POS_W-1:0]  r_span,    n_span;
    t_phase            r_phase,   n_phase;
    logic [SKIP_W-1:0] r_skip,    n_skip;
    logic [VLEN_W-1:0] r_vcount,  n_vcount;
    logic              r_failed,  n_failed;
    logic              r_match,   n_match;

    logic [SKIP_W-1:0] skip_inc;
    logic [POS_W:0]    total;
    logic              short_pkt;
    logic              span_over;
    logic              done;

    assign skip_inc  = r_skip + SKIP_W'(1);
    assign total     = {1'b0, r_pos} + (POS_W+1)'(1);
    assign short_pkt = r_pos < POS_PROT;
    assign span_over = {1'b0, r_span} > total;
    assign done      = i_beat.last_byte || i_beat.empty_packet;

    // next parse state for this beat
    always_comb begin
        n_pos    = r_pos;
        n_span   = r_span;
        n_phase  = r_phase;
        n_skip   = r_skip;
        n_vcount = r_vcount;
        n_failed = r_failed;
        n_match  = r_match;

        if (r_pos < POS_BODY) begin
            case (r_pos)
                POS_LEN0: n_span = {17'd0, i_beat.data_byte};
                POS_LEN1: n_span = r_span | {9'd0, i_beat.data_byte, 8'd0};
                POS_LEN2: n_span = (r_span | {1'b0, i_beat.data_byte, 16'd0}) + SPAN_EXTRA;
                POS_SEQ: begin
                    if (i_beat.data_byte != SEQ_ZERO) n_failed = 1'b1;
                end
                default: begin
                    if (i_beat.data_byte != PROTO_VERSION) n_failed = 1'b1;
                    n_phase = PH_VERSION;
                end
            endcase
        end else if ((r_pos < r_span) && !r_failed) begin
            case (r_phase)
                PH_VERSION: begin
                    if (i_beat.data_byte == STR_END) begin
                        n_vcount = r_pos[VLEN_W-1:0] - VLEN_W'(5);
                        n_skip   = '0;
                        n_phase  = PH_SKIP4;
                    end else if (!is_printable(i_beat.data_byte)) begin
                        n_failed = 1'b1;
                    end
                end
                PH_SKIP4: begin
                    n_skip = skip_inc;
                    if (skip_inc >= SKIP_FIRST) n_phase = PH_SECOND;
                end
                PH_SECOND: begin
                    if (i_beat.data_byte == STR_END) begin
                        n_skip  = '0;
                        n_phase = PH_SKIP5;
                    end else if (!is_printable(i_beat.data_byte)) begin
                        n_failed = 1'b1;
                    end
                end
                PH_SKIP5: begin
                    n_skip = skip_inc;
                    if (skip_inc >= SKIP_SECOND) n_phase = PH_NEED;
                end
                PH_NEED: begin
                    n_match = 1'b1;
                    n_phase = PH_DONE;
                end
                default: ;
            endcase
        end

        n_pos = (r_pos < POS_MAX) ? r_pos + POS_W'(1) : POS_MAX;
    end

    // result for a last or empty beat; span_over uses the held span, which
    // only differs from the new one while the packet is still short
    always_comb begin
        o_result.valid          = i_step && done;
        o_result.verdict        = VERD_IN_PROCESS;
        o_result.version_length = '0;
        if (i_beat.empty_packet || !i_beat.from_responder) begin
            o_result.verdict = VERD_IN_PROCESS;
        end else if (short_pkt || span_over || n_failed || !n_match) begin
            o_result.verdict = VERD_NO_MATCH;
        end else begin
            o_result.verdict        = VERD_MATCH;
            o_result.version_length = n_vcount;
        end
    end

    // parse state; cleared after each result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && done)) begin
            r_pos    <= '0;
            r_span   <= '0;
            r_phase  <= PH_HEADER;
            r_skip   <= '0;
            r_vcount <= '0;
            r_failed <= 1'b0;
            r_match  <= 1'b0;
        end else if (i_step) begin
            r_pos    <= n_pos;
            r_span   <= n_span;
            r_phase  <= n_phase;
            r_skip   <= n_skip;
            r_vcount <= n_vcount;
            r_failed <= n_failed;
            r_match  <= n_match;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/dbhs_checker.sv
// Port-level checker for the greeting validator and its bind statement.
// Depends on dbhs_pkg and the top level's ports.
`default_nettype none

module dbhs_checker
    import dbhs_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);

    // result side clears on reset
    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // only defined verdict codes
    a_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] == VERD_IN_PROCESS ||
                           m_axis_tdata[1:0] == VERD_MATCH ||
                           m_axis_tdata[1:0] == VERD_NO_MATCH))
        else $error("bad verdict code");

    // a length is reported only with a match
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != VERD_MATCH |-> m_axis_tdata[25:2] == 24'd0)
        else $error("version length without match");

    // padding bits stay zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[31:26] == 6'd0)
        else $error("padding bits set");

endmodule

bind db_handshake_greeting_validator dbhs_checker u_dbhs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> tb/dbhs_greeting_checker.sv
// Result checker for the handshake greeting validator: watches the byte and
// result streams, predicts every result beat and compares it field by field.
// Depends on dbhs_pkg.
module dbhs_greeting_checker
    import dbhs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    input  logic [1:0]  s_axis_tuser,   // [0] from_responder, [1] empty_packet
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // [1:0] verdict, [25:2] version_length
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results,
    output int          o_matches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        t_verdict          verdict;
        logic [VLEN_W-1:0] version_length;
    } t_greeting_result;

    // verdicts owed by the block, oldest first
    t_greeting_result pending_verdicts[$];

    // predicted parser state
    logic [POS_W-1:0]  byte_pos;
    logic [POS_W-1:0]  span_len;
    t_phase            parse_ph;
    logic [SKIP_W-1:0] skip_cnt;
    logic [VLEN_W-1:0] version_cnt;
    logic              check_failed;
    logic              body_complete;

    int fail_cnt   = 0;
    int result_cnt = 0;
    int match_cnt  = 0;

    task automatic clear_parser();
        byte_pos      = '0;
        span_len      = '0;
        parse_ph      = PH_HEADER;
        skip_cnt      = '0;
        version_cnt   = '0;
        check_failed  = 1'b0;
        body_complete = 1'b0;
    endtask

    // advance the greeting parser by one byte beat; queue a verdict if one is due
    task automatic parse_greeting_byte(input logic [7:0] b, input logic last,
                                       input logic resp, input logic empty);
        t_greeting_result res;
        logic [POS_W:0]   total;
        res.verdict        = VERD_IN_PROCESS;
        res.version_length = '0;
        if (empty) begin
            // empty marker: drop any partial packet, report in process
            clear_parser();
            pending_verdicts.push_back(res);
        end else begin
            if (byte_pos < POS_BODY) begin
                // fixed header: length, sequence number, protocol byte
                case (byte_pos)
                    POS_LEN0: span_len = POS_W'(b);
                    POS_LEN1: span_len = span_len | (POS_W'(b) << 8);
                    POS_LEN2: span_len = (span_len | (POS_W'(b) << 16)) + SPAN_EXTRA;
                    POS_SEQ: begin
                        if (b != SEQ_ZERO) check_failed = 1'b1;
                    end
                    default: begin
                        if (b != PROTO_VERSION) check_failed = 1'b1;
                        parse_ph = PH_VERSION;
                    end
                endcase
            end else if (byte_pos < span_len && !check_failed) begin
                // body, only inside the span and while nothing has failed
                case (parse_ph)
                    PH_VERSION: begin
                        if (b == STR_END) begin
                            version_cnt = VLEN_W'(byte_pos - POS_BODY);
                            skip_cnt    = '0;
                            parse_ph    = PH_SKIP4;
                        end else if (b < PRINT_LO || b > PRINT_HI) begin
                            check_failed = 1'b1;
                        end
                    end
                    PH_SKIP4: begin
                        skip_cnt = skip_cnt + 1'b1;
                        if (skip_cnt >= SKIP_FIRST) parse_ph = PH_SECOND;
                    end
                    PH_SECOND: begin
                        if (b == STR_END) begin
                            skip_cnt = '0;
                            parse_ph = PH_SKIP5;
                        end else if (b < PRINT_LO || b > PRINT_HI) begin
                            check_failed = 1'b1;
                        end
                    end
                    PH_SKIP5: begin
                        skip_cnt = skip_cnt + 1'b1;
                        if (skip_cnt >= SKIP_SECOND) parse_ph = PH_NEED;
                    end
                    PH_NEED: begin
                        body_complete = 1'b1;
                        parse_ph      = PH_DONE;
                    end
                    default: ;
                endcase
            end

            if (last) begin
                // direction is only looked at on the closing byte
                total = {1'b0, byte_pos} + 1'b1;
                if (!resp) begin
                    res.verdict = VERD_IN_PROCESS;
                end else if (total < {1'b0, POS_BODY} || {1'b0, span_len} > total ||
                             check_failed || !body_complete) begin
                    res.verdict = VERD_NO_MATCH;
                end else begin
                    res.verdict        = VERD_MATCH;
                    res.version_length = version_cnt;
                end
                clear_parser();
                pending_verdicts.push_back(res);
            end else if (byte_pos != POS_MAX) begin
                byte_pos = byte_pos + 1'b1;
            end
        end
    endtask

    // compare one result beat with the oldest outstanding verdict
    task automatic check_result(input logic [31:0] beat);
        t_greeting_result   want;
        logic [VERD_W-1:0]  got_verdict;
        logic [VLEN_W-1:0]  got_len;
        logic [5:0]         got_pad;
        got_verdict = beat[1:0];
        got_len     = beat[25:2];
        got_pad     = beat[31:26];
        result_cnt++;
        if (pending_verdicts.size() == 0) begin
            if (fail_cnt < REPORT_MAX)
                $display("%0t: result beat %h arrived with no verdict outstanding",
                         $time, beat);
            fail_cnt++;
        end else begin
            want = pending_verdicts.pop_front();
            if (want.verdict == VERD_MATCH) match_cnt++;
            if (got_verdict !== want.verdict || got_len !== want.version_length ||
                got_pad !== '0) begin
                if (fail_cnt < REPORT_MAX)
                    $display("%0t: result %0d: expected verdict %0d length %0d,",
                             $time, result_cnt, want.verdict, want.version_length,
                             " got verdict %0d length %0d pad %h",
                             got_verdict, got_len, got_pad);
                fail_cnt++;
            end
        end
    endtask

    // monitor both ports; bytes first so a same-edge result would already be owed
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            pending_verdicts.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                parse_greeting_byte(s_axis_tdata, s_axis_tlast, s_axis_tuser[0],
                                    s_axis_tuser[1]);
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata);
        end
        o_fail_count <= fail_cnt;
        o_pending    <= pending_verdicts.size();
        o_results    <= result_cnt;
        o_matches    <= match_cnt;
    end

endmodule

>>> tb/tb_db_handshake_greeting_validator.sv
// Testbench top for the handshake greeting validator: clock, reset, packet
// stimulus, result-side back-pressure and the final verdict.
// Depends on dbhs_pkg, db_handshake_greeting_validator and dbhs_greeting_checker.
module tb_db_handshake_greeting_validator;
    timeunit 1ns;
    timeprecision 1ps;

    import dbhs_pkg::*;

    localparam int TOTAL_BEATS  = 1250;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;

    // ways a well-formed greeting gets damaged
    typedef enum int {
        DMG_BYTE,
        DMG_TRUNC,
        DMG_LEN,
        DMG_DIR,
        DMG_ABORT
    } t_damage;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] data_byte
    logic        s_axis_tlast  = 1'b0;   // last_byte
    logic [1:0]  s_axis_tuser  = 2'b00;  // [0] from_responder, [1] empty_packet
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [1:0] verdict, [25:2] version_length

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int sent_beats   = 0;
    int sent_packets = 0;
    int cycle_cnt    = 0;
    int fail_count;
    int pending_count;
    int result_count;
    int match_count;

    int tx_idle_by_mix[3]  = '{32, 52, 0};
    int rx_stall_by_mix[3] = '{52, 32, 0};

    // packet under construction
    logic [7:0] pkt[$];

    db_handshake_greeting_validator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    dbhs_greeting_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending_count),
        .o_results     (result_count),
        .o_matches     (match_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d verdicts outstanding",
                     cycle_cnt, pending_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result-side back-pressure
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);

    // one byte beat, with random idle cycles in front of it
    task automatic send_beat(input logic [7:0] data, input logic last,
                             input logic resp, input logic empty);
        logic rdy;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last;
        s_axis_tuser  <= {empty, resp};
        // tready is settled at the falling edge and holds through the next rise
        do begin
            @(negedge i_clk);
            rdy = s_axis_tready;
            @(posedge i_clk);
        end while (!rdy);
        sent_beats++;
    endtask

    task automatic send_empty();
        send_beat(8'($urandom), 1'($urandom), 1'($urandom), 1'b1);
        sent_packets++;
    endtask

    // send pkt; with abort_at >= 0 stop after that many bytes and send an empty marker
    task automatic send_packet(input logic resp, input int abort_at);
        int n;
        n = (abort_at >= 0 && abort_at < pkt.size()) ? abort_at : pkt.size();
        for (int i = 0; i < n; i++) begin
            if (abort_at < 0 && i == n - 1)
                send_beat(pkt[i], 1'b1, resp, 1'b0);
            else
                send_beat(pkt[i], 1'b0, 1'($urandom), 1'b0);
        end
        if (abort_at >= 0) send_empty();
        else sent_packets++;
    endtask

    // little-endian payload length in the first three bytes
    task automatic set_span_len(input int len_val);
        pkt[0] = len_val[7:0];
        pkt[1] = len_val[15:8];
        pkt[2] = len_val[23:16];
    endtask

    // well-formed greeting; extra bytes inside the span, tail bytes beyond it
    task automatic build_greeting(input int vlen, input int slen, input int extra,
                                  input int tail);
        pkt.delete();
        repeat (3) pkt.push_back(8'h00);
        pkt.push_back(SEQ_ZERO);
        pkt.push_back(PROTO_VERSION);
        repeat (vlen) pkt.push_back(8'($urandom_range(PRINT_HI, PRINT_LO)));
        pkt.push_back(STR_END);
        repeat (4) pkt.push_back(8'($urandom));
        repeat (slen) pkt.push_back(8'($urandom_range(PRINT_HI, PRINT_LO)));
        pkt.push_back(STR_END);
        repeat (5) pkt.push_back(8'($urandom));
        repeat (1 + extra) pkt.push_back(8'($urandom));
        set_span_len(pkt.size() - int'(SPAN_EXTRA));
        repeat (tail) pkt.push_back(8'($urandom));
    endtask

    // mostly greetings with random content, some damaged, some noise and empties
    task automatic send_random_packet();
        int      roll;
        int      vlen;
        t_damage dmg;
        roll = $urandom_range(99);
        if (roll < 10) begin
            send_empty();
        end else if (roll < 25) begin
            pkt.delete();
            repeat ($urandom_range(24, 1)) pkt.push_back(8'($urandom));
            send_packet(1'($urandom), -1);
        end else begin
            vlen = ($urandom_range(99) < 4) ? $urandom_range(120, 40) : $urandom_range(12);
            build_greeting(vlen, $urandom_range(10), $urandom_range(3),
                           ($urandom_range(3) == 0) ? $urandom_range(4, 1) : 0);
            if (roll < 65) begin
                send_packet(1'b1, -1);
            end else begin
                dmg = t_damage'($urandom_range(DMG_ABORT));
                case (dmg)
                    DMG_BYTE:  pkt[$urandom_range(pkt.size() - 1)] = 8'($urandom);
                    DMG_TRUNC: repeat ($urandom_range(pkt.size() - 1, 1)) void'(pkt.pop_back());
                    DMG_LEN:   set_span_len(pkt.size() - 7 + int'($urandom_range(6)));
                    default: ;
                endcase
                send_packet(1'(dmg != DMG_DIR),
                            (dmg == DMG_ABORT) ? int'($urandom_range(pkt.size() - 1)) : -1);
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tx_idle_pct  = tx_idle_by_mix[0];
        rx_stall_pct = rx_stall_by_mix[0];

        // empty marker on an idle parser
        send_empty();
        // smallest greeting: both strings empty, one byte after the skips
        build_greeting(0, 0, 0, 0);
        send_packet(1'b1, -1);
        // printable extremes in the version string
        build_greeting(3, 2, 0, 0);
        pkt[5] = PRINT_LO;
        pkt[7] = PRINT_HI;
        send_packet(1'b1, -1);
        // same bytes travelling client to server
        send_packet(1'b0, -1);
        // bytes past the span only count as packet bytes
        build_greeting(2, 1, 2, 3);
        send_packet(1'b1, -1);
        // packets too short for a header
        pkt = '{8'h11, 8'h00, 8'h00, 8'h00};
        send_packet(1'b1, -1);
        pkt = '{8'hFF};
        send_packet(1'b1, -1);
        // span runs past the end of the packet
        build_greeting(1, 1, 0, 0);
        void'(pkt.pop_back());
        send_packet(1'b1, -1);
        // bad sequence number, then bad protocol byte
        build_greeting(4, 4, 0, 0);
        pkt[3] = 8'hFF;
        send_packet(1'b1, -1);
        pkt[3] = SEQ_ZERO;
        pkt[4] = 8'h09;
        send_packet(1'b1, -1);
        // non-printable bytes inside the strings
        build_greeting(2, 3, 0, 0);
        pkt[6] = 8'h7F;
        send_packet(1'b1, -1);
        pkt[6] = PRINT_HI;
        pkt[5] = 8'hFF;
        send_packet(1'b1, -1);
        build_greeting(2, 3, 0, 0);
        pkt[13] = 8'h1F;
        send_packet(1'b1, -1);
        // span closes before the byte that must follow the second skip
        build_greeting(1, 1, 0, 2);
        set_span_len(pkt.size() - 7);
        send_packet(1'b1, -1);
        // all-ones length field
        pkt = '{8'hFF, 8'hFF, 8'hFF, SEQ_ZERO, PROTO_VERSION, 8'h41, STR_END, 8'hFF};
        send_packet(1'b1, -1);
        // partial greeting dropped by an empty marker, then the whole one
        build_greeting(5, 5, 1, 0);
        send_packet(1'b1, 9);
        send_packet(1'b1, -1);
        // long version string
        build_greeting(100, 30, 0, 0);
        send_packet(1'b1, -1);

        // random traffic under each idle mix in turn
        for (int mix = 0; mix < 3; mix++) begin
            tx_idle_pct  = tx_idle_by_mix[mix];
            rx_stall_pct = rx_stall_by_mix[mix];
            while (sent_beats < TOTAL_BEATS * (mix + 1) / 3)
                send_random_packet();
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d byte beats in %0d packets across three idle mixes",
                 sent_beats, sent_packets);
        $display("checked %0d result beats, %0d of them greeting matches",
                 result_count, match_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> db_handshake_greeting_validator.f
rtl/core/dbhs_pkg.sv
rtl/core/dbhs_parser.sv
rtl/core/db_handshake_greeting_validator.sv
rtl/core/dbhs_checker.sv
tb/dbhs_greeting_checker.sv
tb/tb_db_handshake_greeting_validator.sv
